### src/sos_pkg.sv
// sos_pkg: shared types and constants for the solid-on-solid Metropolis step unit
// field widths, register indexes, threshold selects and reset values
// no dependencies
package sos_pkg;

  localparam int CENTER_W   = 9;
  localparam int SITE_W     = 6;
  localparam int RND_W      = 32;
  localparam int THR_W      = 33;
  localparam int SUM_W      = 15;
  localparam int OUT_H_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_THR    = 6;
  // widest height plus a carry bit plus sign
  localparam int HMAX_W     = 16;
  localparam int DD_W       = HMAX_W + 2;

  localparam logic [SUM_W-1:0]    SUM_MAX    = 15'h7fff;
  localparam logic [THR_W-1:0]    THR_RST    = 33'h1_0000_0000;
  localparam logic [CENTER_W-1:0] RST_CENTER = 9'd30;
  localparam int                  RST_HEIGHT = 30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BD_DU  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BU_DD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd6;

  // threshold select: bond down/same/up, distance up/down
  typedef enum logic [2:0] {
    THR_BD_DU = 3'd0,
    THR_BD_DD = 3'd1,
    THR_BS_DU = 3'd2,
    THR_BS_DD = 3'd3,
    THR_BU_DU = 3'd4,
    THR_BU_DD = 3'd5
  } thr_sel_t;

  // decision from the evaluate stage
  typedef struct packed {
    logic     fits;     // move is legal (or set action changes the height)
    logic     direct;   // set action: commit without threshold test
    thr_sel_t thr_sel;
  } move_ctl_t;

endpackage

### src/sos_move.sv
// sos_move: evaluates one proposed move from the site height and its two neighbors
// produces new height, legality, threshold select and distance change
// depends on sos_pkg
module sos_move #(
  parameter int HEIGHT_BITS = 10
) (
  input  logic                           action,
  input  logic                           step_up,
  input  logic [HEIGHT_BITS-1:0]         h,
  input  logic [HEIGHT_BITS-1:0]         hl,
  input  logic [HEIGHT_BITS-1:0]         hr,
  input  logic [sos_pkg::CENTER_W-1:0]   center,
  output sos_pkg::move_ctl_t             ctl,
  output logic [HEIGHT_BITS-1:0]         nh,
  output logic signed [sos_pkg::DD_W-1:0] dd
);

  localparam int VW = ((HEIGHT_BITS > sos_pkg::CENTER_W) ? HEIGHT_BITS : sos_pkg::CENTER_W) + 1;

  function automatic logic [VW-1:0] adiff(input logic [VW-1:0] a, input logic [VW-1:0] b);
    adiff = (a > b) ? a - b : b - a;
  endfunction

  logic [VW-1:0] hv, lv, rv, cv;
  logic [VW-1:0] nh_up, nh_dn, nh_set, nh_sel;
  logic          fits_up, fits_dn;
  logic [VW:0]   sum_new, sum_old;
  logic [VW-1:0] d_new, d_old;
  logic          dist_dn;
  logic signed [VW:0] dd_v;

  assign hv = VW'(h);
  assign lv = VW'(hl);
  assign rv = VW'(hr);
  assign cv = VW'(center);

  assign nh_up   = hv + 1'b1;
  assign nh_dn   = hv - 1'b1;
  assign fits_up = (nh_up <= (cv << 1)) && (h != {HEIGHT_BITS{1'b1}});
  assign fits_dn = (h != '0);
  // set action stores the center masked to the height width
  assign nh_set  = VW'(HEIGHT_BITS'(center));
  assign nh_sel  = action ? nh_set : (step_up ? nh_up : nh_dn);

  assign sum_new = {1'b0, adiff(nh_sel, lv)} + {1'b0, adiff(nh_sel, rv)};
  assign sum_old = {1'b0, adiff(hv, lv)} + {1'b0, adiff(hv, rv)};
  assign d_new   = adiff(cv, nh_sel);
  assign d_old   = adiff(cv, hv);
  assign dist_dn = d_new < d_old;
  assign dd_v    = $signed({1'b0, d_new}) - $signed({1'b0, d_old});

  always_comb begin
    ctl.direct = action;
    ctl.fits   = action ? (nh_set != hv) : (step_up ? fits_up : fits_dn);
    if (sum_new < sum_old) begin
      ctl.thr_sel = dist_dn ? sos_pkg::THR_BD_DD : sos_pkg::THR_BD_DU;
    end else if (sum_new == sum_old) begin
      ctl.thr_sel = dist_dn ? sos_pkg::THR_BS_DD : sos_pkg::THR_BS_DU;
    end else begin
      ctl.thr_sel = dist_dn ? sos_pkg::THR_BU_DD : sos_pkg::THR_BU_DU;
    end
  end

  assign nh = nh_sel[HEIGHT_BITS-1:0];
  assign dd = sos_pkg::DD_W'(dd_v);

endmodule

### src/sos_interface_metropolis_step_unit.sv
// sos_interface_metropolis_step_unit: top level of the solid-on-solid Metropolis step
// height memory, sequencer, configuration registers, commit logic and result register
// depends on sos_pkg and sos_move
//
// Usage: each request on the in_ channel names a site and either proposes a one-step
// move (action 0, direction step_up) or sets the site to the center height (action 1).
// random_word is compared with one of six acceptance thresholds picked by the sign of
// the bond change and of the distance change. One result per request leaves on the
// out_ channel: accepted flag, new height of the site and the running distance sum.
// A set action skips the threshold compare. Heights live in a single-port-read memory;
// the three reads (site, left, right) go through that one read port, then an evaluate
// cycle and a commit cycle follow. The result register is loaded in the commit cycle,
// when the sequencer also returns to idle. in_ready is high only in the idle state.
// If the receiver stalls, the result sits in the output register and the sequencer
// holds in its commit cycle until the register can be loaded.
// After reset a clearing pass writes height 30 into every entry, with in_ready low;
// configuration writes are taken at any time through cfg_we.
// Requests with site >= SITES change nothing and return height 0.
module sos_interface_metropolis_step_unit #(
  parameter int SITES       = 64,
  parameter int HEIGHT_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [sos_pkg::SITE_W-1:0]      in_site,
  input  logic                            in_step_up,
  input  logic [sos_pkg::RND_W-1:0]       in_random_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [sos_pkg::OUT_H_W-1:0]     out_site_height,
  output logic [sos_pkg::SUM_W-1:0]       out_distance_sum,
  input  logic                            cfg_we,
  input  logic [sos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sos_pkg::THR_W-1:0]       cfg_data
);

  localparam int IW = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int XW = 13;
  localparam int SW = sos_pkg::DD_W + 1;

  typedef enum logic [5:0] {
    S_CLR    = 6'b000001,
    S_IDLE   = 6'b000010,
    S_RD_L   = 6'b000100,
    S_RD_R   = 6'b001000,
    S_EVAL   = 6'b010000,
    S_COMMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [sos_pkg::THR_W-1:0]    thr_r [sos_pkg::NUM_THR];
  logic [sos_pkg::CENTER_W-1:0] center_r;
  logic [sos_pkg::SUM_W-1:0]    dist_r;

  logic [HEIGHT_BITS-1:0] mem [SITES];
  logic [HEIGHT_BITS-1:0] rd_data_r;
  logic [IW-1:0]          raddr, waddr;
  logic [HEIGHT_BITS-1:0] wdata;
  logic                   mem_we;
  logic [IW-1:0]          clr_cnt_r;

  logic                      action_r, step_up_r, in_range_r;
  logic [IW-1:0]             site_r;
  logic [sos_pkg::RND_W-1:0] rnd_r;
  logic [HEIGHT_BITS-1:0]    h_r, hl_r;

  sos_pkg::move_ctl_t           ctl_c, ctl_r;
  logic [HEIGHT_BITS-1:0]       nh_c, nh_r;
  logic signed [sos_pkg::DD_W-1:0] dd_c, dd_r;

  logic [XW-1:0]          in_site_x;
  logic [IW-1:0]          in_idx, left_idx, right_idx;
  logic                   in_range_c;
  logic                   in_acc, commit, take;
  logic signed [SW-1:0]   sum_v;
  logic [sos_pkg::SUM_W-1:0] dist_sat;
  logic [HEIGHT_BITS-1:0] h_new;

  logic                             out_valid_r;
  logic                             out_accepted_r;
  logic [sos_pkg::OUT_H_W-1:0]      out_height_r;
  logic [sos_pkg::SUM_W-1:0]        out_sum_r;

  assign in_site_x  = XW'(in_site);
  assign in_idx     = in_site_x[IW-1:0];
  assign in_range_c = 32'(in_site) < 32'(SITES);
  assign left_idx   = (site_r == '0) ? IW'(SITES - 1) : site_r - 1'b1;
  assign right_idx  = (site_r == IW'(SITES - 1)) ? '0 : site_r + 1'b1;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign commit   = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  assign take     = in_range_r && ctl_r.fits &&
                    (ctl_r.direct || ({1'b0, rnd_r} < thr_r[ctl_r.thr_sel]));

  // state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:    if (clr_cnt_r == IW'(SITES - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_RD_L;
      S_RD_L:   state_nxt = S_RD_R;
      S_RD_R:   state_nxt = S_EVAL;
      S_EVAL:   state_nxt = S_COMMIT;
      S_COMMIT: if (commit) state_nxt = S_IDLE;
      default:  state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // memory address and write port
  always_comb begin
    case (state_r)
      S_RD_L:  raddr = left_idx;
      S_RD_R:  raddr = right_idx;
      S_IDLE:  raddr = in_idx;
      default: raddr = site_r;
    endcase
  end

  assign mem_we = (state_r == S_CLR) || (commit && take);
  assign waddr  = (state_r == S_CLR) ? clr_cnt_r : site_r;
  assign wdata  = (state_r == S_CLR) ? HEIGHT_BITS'(sos_pkg::RST_HEIGHT) : nh_r;

  // the next read is issued after the commit write, so no forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sos_pkg::NUM_THR; i++) begin
        thr_r[i] <= sos_pkg::THR_RST;
      end
      center_r <= sos_pkg::RST_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [sos_pkg::CFG_BD_DU:sos_pkg::CFG_BU_DD]: thr_r[cfg_index] <= cfg_data;
        sos_pkg::CFG_CENTER: center_r <= cfg_data[sos_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and operand collection
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r   <= in_action;
      step_up_r  <= in_step_up;
      site_r     <= in_idx;
      in_range_r <= in_range_c;
      rnd_r      <= in_random_word;
    end
    if (state_r == S_RD_L) h_r <= rd_data_r;
    if (state_r == S_RD_R) hl_r <= rd_data_r;
    if (state_r == S_EVAL) begin
      ctl_r <= ctl_c;
      nh_r  <= nh_c;
      dd_r  <= dd_c;
    end
  end

  sos_move #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_move (
    .action (action_r),
    .step_up(step_up_r),
    .h      (h_r),
    .hl     (hl_r),
    .hr     (rd_data_r),
    .center (center_r),
    .ctl    (ctl_c),
    .nh     (nh_c),
    .dd     (dd_c)
  );

  // saturating distance update
  assign sum_v = $signed({{(SW - sos_pkg::SUM_W){1'b0}}, dist_r}) +
                 $signed({dd_r[sos_pkg::DD_W-1], dd_r});

  always_comb begin
    if (sum_v[SW-1]) begin
      dist_sat = '0;
    end else if (sum_v[SW-2:0] > (SW-1)'(sos_pkg::SUM_MAX)) begin
      dist_sat = sos_pkg::SUM_MAX;
    end else begin
      dist_sat = sum_v[sos_pkg::SUM_W-1:0];
    end
  end

  assign h_new = take ? nh_r : h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
        if (take) dist_r <= dist_sat;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_accepted_r <= take;
      out_height_r   <= in_range_r ? sos_pkg::OUT_H_W'(h_new) : '0;
      out_sum_r      <= take ? dist_sat : dist_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_site_height  = out_height_r;
  assign out_distance_sum = out_sum_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLR || state_r == S_COMMIT))
    else $error("height memory written outside clear or commit");

  a_commit_changes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && mem_we) |-> (wdata != h_r))
    else $error("accepted move leaves the height unchanged");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result loaded outside the commit cycle");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |=> !$past(in_acc))
    else $error("request taken during the clearing pass");

endmodule

### tb/testbench.sv
// testbench: self-checking bench for sos_interface_metropolis_step_unit
// drives site requests and register writes, predicts each result and checks it in order
// depends on sos_pkg and the unit under test
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SITES       = 64;
  localparam int HEIGHT_BITS = 10;
  localparam int HMASK       = (1 << HEIGHT_BITS) - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 8;
  localparam logic ACT_MOVE  = 1'b0;
  localparam logic ACT_SET   = 1'b1;
  localparam logic [sos_pkg::THR_W-1:0] THR_NEVER  = '0;
  localparam logic [sos_pkg::THR_W-1:0] THR_ALWAYS = 33'h1_0000_0000;

  typedef struct {
    logic                        action;
    logic [sos_pkg::SITE_W-1:0]  site;
    logic                        step_up;
    logic [sos_pkg::RND_W-1:0]   word;
    logic                        wait_drain;
  } move_req_t;

  typedef struct {
    logic                        accepted;
    logic [sos_pkg::OUT_H_W-1:0] height;
    logic [sos_pkg::SUM_W-1:0]   dist_sum;
  } step_result_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_action = 1'b0;
  logic [sos_pkg::SITE_W-1:0]    in_site = '0;
  logic                          in_step_up = 1'b0;
  logic [sos_pkg::RND_W-1:0]     in_random_word = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b1;
  logic                          out_accepted;
  logic [sos_pkg::OUT_H_W-1:0]   out_site_height;
  logic [sos_pkg::SUM_W-1:0]     out_distance_sum;
  logic                          cfg_we = 1'b0;
  logic [sos_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sos_pkg::THR_W-1:0]     cfg_data = '0;

  sos_interface_metropolis_step_unit #(
    .SITES       (SITES),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_site          (in_site),
    .in_step_up       (in_step_up),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_site_height  (out_site_height),
    .out_distance_sum (out_distance_sum),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow of the lattice and registers
  logic [HEIGHT_BITS-1:0]         lattice_h [SITES];
  int                             dist_acc;
  logic [sos_pkg::THR_W-1:0]      accept_thr [sos_pkg::NUM_THR];
  logic [sos_pkg::CENTER_W-1:0]   center_ref;

  move_req_t    pending_moves[$];
  step_result_t expected_results[$];

  int  err_count   = 0;
  int  n_requests  = 0;
  int  n_results   = 0;
  int  n_changed   = 0;
  int  max_height  = 0;
  int  max_dist    = 0;
  int  cycle_count = 0;
  int  send_gap    = 0;
  int  stall_left  = 0;
  int  up_bias     = 50;
  bit  idle_free   = 1'b0;
  logic in_fire    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int sat_dist(int v);
    if (v < 0) return 0;
    if (v > int'(sos_pkg::SUM_MAX)) return int'(sos_pkg::SUM_MAX);
    return v;
  endfunction

  // advance the shadow lattice by one request and return the result it gives
  function automatic step_result_t metropolis_step(move_req_t r);
    step_result_t      res;
    int                s, h, c, nh, lft, rgt, bond, dd;
    logic              fits;
    sos_pkg::thr_sel_t sel;
    res.accepted = 1'b0;
    res.height   = '0;
    s = int'(r.site);
    if (s < SITES) begin
      h = int'(lattice_h[s]);
      c = int'(center_ref);
      if (r.action == ACT_SET) begin
        nh = c & HMASK;
        if (nh != h) begin
          dist_acc     = sat_dist(dist_acc + abs_diff(c, nh) - abs_diff(c, h));
          lattice_h[s] = nh[HEIGHT_BITS-1:0];
          res.accepted = 1'b1;
        end
      end else begin
        rgt = int'(lattice_h[(s + 1) % SITES]);
        lft = int'(lattice_h[(s + SITES - 1) % SITES]);
        if (r.step_up) begin
          fits = (h + 1 <= 2 * c) && (h + 1 <= HMASK);
          nh   = h + 1;
        end else begin
          fits = (h >= 1);
          nh   = fits ? h - 1 : 0;
        end
        if (fits) begin
          bond = abs_diff(nh, lft) + abs_diff(nh, rgt) - abs_diff(h, lft) - abs_diff(h, rgt);
          dd   = abs_diff(c, nh) - abs_diff(c, h);
          if (bond < 0) sel = (dd < 0) ? sos_pkg::THR_BD_DD : sos_pkg::THR_BD_DU;
          else if (bond == 0) sel = (dd < 0) ? sos_pkg::THR_BS_DD : sos_pkg::THR_BS_DU;
          else sel = (dd < 0) ? sos_pkg::THR_BU_DD : sos_pkg::THR_BU_DU;
          if ({1'b0, r.word} < accept_thr[sel]) begin
            lattice_h[s] = nh[HEIGHT_BITS-1:0];
            dist_acc     = sat_dist(dist_acc + dd);
            res.accepted = 1'b1;
          end
        end
      end
      res.height = sos_pkg::OUT_H_W'(lattice_h[s]);
    end
    res.dist_sum = sos_pkg::SUM_W'(dist_acc);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < 50)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  task automatic push_req(logic action, int site, logic up,
                          logic [sos_pkg::RND_W-1:0] word, logic wait_drain = 1'b0);
    move_req_t r;
    r.action     = action;
    r.site       = sos_pkg::SITE_W'(site);
    r.step_up    = up;
    r.word       = word;
    r.wait_drain = wait_drain;
    pending_moves.push_back(r);
  endtask

  task automatic queue_random(int n);
    int                        k, pick, base, site, t_idx;
    logic                      action, up;
    logic [sos_pkg::RND_W-1:0] word;
    logic [sos_pkg::THR_W-1:0] t;
    base = $urandom_range(0, 63);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) base = $urandom_range(0, 63);
      // clustered sites make neighbors interact, some clusters wrap the ring
      site   = ($urandom_range(0, 99) < 45) ? (base + $urandom_range(0, 3)) % SITES
                                            : $urandom_range(0, 63);
      action = ($urandom_range(0, 99) < 12) ? ACT_SET : ACT_MOVE;
      up     = ($urandom_range(0, 99) < up_bias);
      pick   = $urandom_range(0, 99);
      if (pick < 15) word = '0;
      else if (pick < 25) word = '1;
      else if (pick < 40) begin
        t_idx = $urandom_range(0, sos_pkg::NUM_THR - 1);
        t     = accept_thr[t_idx];
        if (t == '0) word = '0;
        else if (t >= THR_ALWAYS) word = '1;
        else word = t[sos_pkg::RND_W-1:0] - sos_pkg::RND_W'($urandom_range(0, 1));
      end else word = $urandom();
      push_req(action, site, up, word, $urandom_range(0, 149) == 0);
    end
  endtask

  task automatic write_reg(logic [sos_pkg::CFG_IDX_W-1:0] idx,
                           logic [sos_pkg::THR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == sos_pkg::CFG_CENTER) center_ref = val[sos_pkg::CENTER_W-1:0];
    else if (int'(idx) < sos_pkg::NUM_THR) accept_thr[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all_thr(logic [sos_pkg::THR_W-1:0] val);
    int k;
    for (k = int'(sos_pkg::THR_BD_DU); k <= int'(sos_pkg::THR_BU_DD); k++)
      write_reg(sos_pkg::CFG_IDX_W'(k), val);
  endtask

  // block idle: nothing queued, nothing presented, nothing outstanding
  task automatic wait_idle();
    @(posedge clk);
    while (pending_moves.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    move_req_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the request until it is taken
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_moves.size() != 0 &&
                 (!pending_moves[0].wait_drain || expected_results.size() == 0)) begin
      cur = pending_moves.pop_front();
      in_action      <= cur.action;
      in_site        <= cur.site;
      in_step_up     <= cur.step_up;
      in_random_word <= cur.word;
      in_valid       <= 1'b1;
      send_gap       <= idle_free ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!idle_free && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // monitor: predict on each taken request, check each delivered result
  always @(posedge clk) begin
    move_req_t    r;
    step_result_t want;
    cycle_count <= cycle_count + 1;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      r.action     = in_action;
      r.site       = in_site;
      r.step_up    = in_step_up;
      r.word       = in_random_word;
      r.wait_drain = 1'b0;
      expected_results.push_back(metropolis_step(r));
      n_requests++;
    end
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_accepted) n_changed++;
      if (int'(out_site_height) > max_height) max_height = int'(out_site_height);
      if (int'(out_distance_sum) > max_dist) max_dist = int'(out_distance_sum);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, height", out_site_height, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", out_accepted, want.accepted);
        if (out_site_height !== want.height)
          report_mismatch("site_height", out_site_height, want.height);
        if (out_distance_sum !== want.dist_sum)
          report_mismatch("distance_sum", out_distance_sum, want.dist_sum);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int k;
    logic [sos_pkg::THR_W-1:0] t;
    for (k = 0; k < sos_pkg::NUM_THR; k++) accept_thr[k] = sos_pkg::THR_RST;
    center_ref = sos_pkg::RST_CENTER;
    for (k = 0; k < SITES; k++) lattice_h[k] = HEIGHT_BITS'(sos_pkg::RST_HEIGHT);
    dist_acc = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: every move that fits is accepted
    push_req(ACT_SET, 5, 1'b0, '0);
    push_req(ACT_MOVE, 0, 1'b1, '1);
    push_req(ACT_MOVE, 0, 1'b0, '0);
    push_req(ACT_MOVE, 63, 1'b1, 32'h8000_0000);
    push_req(ACT_MOVE, 1, 1'b0, 32'h7fff_ffff);
    push_req(ACT_MOVE, 0, 1'b1, 32'h5555_5555);
    queue_random(150);
    wait_idle();

    // smallest center: floor and ceiling of the allowed band
    write_reg(sos_pkg::CFG_CENTER, sos_pkg::THR_W'(1));
    push_req(ACT_SET, 10, 1'b0, '0);
    push_req(ACT_MOVE, 10, 1'b0, '1);
    push_req(ACT_MOVE, 10, 1'b0, '0);
    push_req(ACT_MOVE, 10, 1'b1, 32'haaaa_aaaa);
    push_req(ACT_MOVE, 10, 1'b1, '0);
    push_req(ACT_MOVE, 10, 1'b1, '0);
    queue_random(150);
    wait_idle();

    // center zero: only height zero allowed
    write_reg(sos_pkg::CFG_CENTER, sos_pkg::THR_W'(0));
    push_req(ACT_SET, 10, 1'b0, '0);
    push_req(ACT_MOVE, 10, 1'b1, '0);
    push_req(ACT_MOVE, 10, 1'b0, '0);
    queue_random(100);
    wait_idle();

    // largest center, thresholds that never accept
    write_reg(sos_pkg::CFG_CENTER, sos_pkg::THR_W'(511));
    set_all_thr(THR_NEVER);
    push_req(ACT_SET, 20, 1'b0, '0);
    push_req(ACT_MOVE, 20, 1'b1, '0);
    queue_random(150);
    wait_idle();

    // largest center, always accept, climbing past bit nine
    set_all_thr(THR_ALWAYS);
    idle_free = 1'b1;
    up_bias   = 75;
    push_req(ACT_MOVE, 20, 1'b1, '1);
    push_req(ACT_MOVE, 20, 1'b1, '1);
    queue_random(200);
    wait_idle();
    idle_free = 1'b0;
    up_bias   = 50;

    // one shared threshold: check the strict compare at its edge
    t = sos_pkg::THR_W'($urandom_range(1, 32'hffff_fffe));
    set_all_thr(t);
    write_reg(sos_pkg::CFG_CENTER, sos_pkg::THR_W'($urandom_range(1, 511)));
    push_req(ACT_SET, 30, 1'b0, '0, 1'b1);
    push_req(ACT_MOVE, 30, 1'b1, t[sos_pkg::RND_W-1:0] - 1'b1);
    push_req(ACT_MOVE, 30, 1'b0, t[sos_pkg::RND_W-1:0]);
    queue_random(200);
    wait_idle();

    // mixed thresholds around the reset center
    write_reg(sos_pkg::CFG_CENTER, sos_pkg::THR_W'(sos_pkg::RST_CENTER));
    for (k = int'(sos_pkg::THR_BD_DU); k <= int'(sos_pkg::THR_BU_DD); k++) begin
      case ($urandom_range(0, 2))
        0:       t = THR_NEVER;
        1:       t = THR_ALWAYS;
        default: t = sos_pkg::THR_W'($urandom());
      endcase
      write_reg(sos_pkg::CFG_IDX_W'(k), t);
    end
    queue_random(150);
    wait_idle();

    $display("covered %0d requests over seven register settings, %0d heights changed",
             n_requests, n_changed);
    $display("largest height seen %0d, largest distance sum seen %0d", max_height, max_dist);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
